/* hw/rtl/pnv_pkg.sv */
// Shared types, codes and tables for the pulse/noise voice synthesizer.
// No dependencies; used by pnv_front, pnv_back and the top level.
package pnv_pkg;

    localparam int SAMPLE_RATE_DEF = 22050;
    localparam int VOICES          = 3;

    localparam logic [2:0] CMD_TICK   = 3'd0;
    localparam logic [2:0] CMD_PULSE  = 3'd1;
    localparam logic [2:0] CMD_NOISE  = 3'd2;
    localparam logic [2:0] CMD_SIL    = 3'd3;
    localparam logic [2:0] CMD_SILALL = 3'd4;

    localparam logic [1:0]  NOISE_VOICE  = 2'd2;
    localparam logic [1:0]  NO_VOICE     = 2'd3;
    localparam logic [3:0]  MASTER_RESET = 4'd10;
    localparam logic [3:0]  MASTER_MAX   = 4'd10;
    localparam logic [10:0] SCALE_STEP   = 11'd150;
    localparam logic [14:0] LFSR_SEED    = 15'h7FFF;
    localparam logic [15:0] MS_PER_SEC   = 16'd1000;
    localparam logic [15:0] NOISE_DEF    = 16'd4;
    localparam logic [31:0] PHASE_ONE    = 32'h0001_0000;
    localparam logic [3:0]  LEVEL_MAX    = 4'd15;

    typedef enum logic [2:0] {
        OP_TICK,
        OP_PULSE,
        OP_NOISE,
        OP_SIL,
        OP_SILALL
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_VOICE,
        ST_MUL,
        ST_OUT,
        ST_DIVN,
        ST_LOAD
    } state_t;

    typedef struct packed {
        op_t                op;
        logic [1:0]         voice;
        logic [15:0]        phase_step;
        logic [1:0]         duty;
        logic [7:0]         volume;
        logic signed [4:0]  env_direction;
        logic [7:0]         env_period;
        logic [15:0]        duration_ms;
        logic [15:0]        noise_period;
    } item_t;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [15:0] divisor;
    } div_req_t;

    function automatic logic [15:0] duty_threshold(input logic [1:0] sel);
        logic [15:0] t;
        case (sel)
            2'd0:    t = 16'h2000;
            2'd1:    t = 16'h4000;
            2'd2:    t = 16'h8000;
            default: t = 16'hC000;
        endcase
        return t;
    endfunction

endpackage

/* hw/rtl/pnv_div.sv */
// Shift-subtract divider, two quotient bits per cycle.
// Uses nothing from the package; instantiated by pnv_back.
module pnv_div #(
    parameter int DW = 32,
    parameter int VW = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          busy,
    output logic          done,
    output logic [DW-1:0] quotient
);
    localparam int STEPS = DW / 2;
    localparam int CW    = $clog2(STEPS + 1);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] dvd_reg, dvd_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [VW:0]   rem_reg, rem_next;
    logic [VW-1:0] dsr_reg;
    logic          done_reg;

    always_comb begin
        logic [VW:0] r;
        r        = rem_reg;
        dvd_next = dvd_reg;
        quo_next = quo_reg;
        for (int i = 0; i < 2; i++) begin
            r        = {r[VW-1:0], dvd_next[DW-1]};
            dvd_next = {dvd_next[DW-2:0], 1'b0};
            if (r >= {1'b0, dsr_reg}) begin
                r        = r - {1'b0, dsr_reg};
                quo_next = {quo_next[DW-2:0], 1'b1};
            end else begin
                quo_next = {quo_next[DW-2:0], 1'b0};
            end
        end
        rem_next = r;
        cnt_next = cnt_reg - CW'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= CW'(STEPS);
                dvd_reg <= dividend;
                dsr_reg <= divisor;
                rem_reg <= '0;
                quo_reg <= '0;
            end else if (cnt_reg != '0) begin
                cnt_reg  <= cnt_next;
                dvd_reg  <= dvd_next;
                rem_reg  <= rem_next;
                quo_reg  <= quo_next;
                done_reg <= (cnt_reg == CW'(1));
            end
        end
    end

    assign busy     = (cnt_reg != '0);
    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

/* hw/rtl/pnv_front.sv */
// Front end: accepts input transactions, classifies commands, drops invalid
// commands and queues the rest in a two-entry FIFO. Depends on pnv_pkg.
module pnv_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    // phase_step, duty, volume, env_direction, env_period, duration_ms,
    // noise_period, zero pad
    input  logic [71:0]   s_tdata,
    // command, voice
    input  logic [4:0]    s_tuser,
    output logic          q_valid,
    output pnv_pkg::item_t q_item,
    input  logic          q_pop
);
    pnv_pkg::item_t mem_reg [2];
    logic           wr_ptr_reg, rd_ptr_reg;
    logic [1:0]     count_reg;
    pnv_pkg::item_t item;
    logic           keep, push, pop;
    logic [2:0]     cmd;

    assign cmd = s_tuser[2:0];

    always_comb begin
        item.voice         = s_tuser[4:3];
        item.phase_step    = s_tdata[15:0];
        item.duty          = s_tdata[17:16];
        item.volume        = s_tdata[25:18];
        item.env_direction = $signed(s_tdata[30:26]);
        item.env_period    = s_tdata[38:31];
        item.duration_ms   = s_tdata[54:39];
        item.noise_period  = s_tdata[70:55];
        item.op            = pnv_pkg::OP_TICK;
        keep               = 1'b0;
        case (cmd)
            pnv_pkg::CMD_TICK: begin
                keep = 1'b1;
            end
            pnv_pkg::CMD_PULSE: begin
                item.op = pnv_pkg::OP_PULSE;
                keep    = !item.voice[1];
            end
            pnv_pkg::CMD_NOISE: begin
                item.op = pnv_pkg::OP_NOISE;
                keep    = 1'b1;
            end
            pnv_pkg::CMD_SIL: begin
                item.op = pnv_pkg::OP_SIL;
                keep    = (item.voice != pnv_pkg::NO_VOICE);
            end
            pnv_pkg::CMD_SILALL: begin
                item.op = pnv_pkg::OP_SILALL;
                keep    = 1'b1;
            end
            default: keep = 1'b0;
        endcase
    end

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready && keep;
    assign pop      = q_pop && q_valid;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                mem_reg[wr_ptr_reg] <= item;
                wr_ptr_reg          <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd2) |-> !push)
        else $error("queue overflow");
endmodule

/* hw/rtl/pnv_back.sv */
// Back end: voice state, command sequencer, tick mixer and output register.
// Depends on pnv_pkg and pnv_div.
module pnv_back #(
    parameter int SAMPLE_RATE = pnv_pkg::SAMPLE_RATE_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    input  pnv_pkg::item_t q_item,
    output logic           q_pop,
    input  logic [3:0]     master,
    output logic           m_tvalid,
    input  logic           m_tready,
    // sample, any_active, zero pad
    output logic [23:0]    m_tdata
);
    localparam int ENV_TICKS = SAMPLE_RATE / 64;
    // ms to samples by reciprocal multiply, exact for every 16-bit ms value
    localparam int          SAMPLES_SHIFT = 27;
    localparam logic [63:0] SAMPLES_MUL   =
        ((64'(SAMPLE_RATE) << SAMPLES_SHIFT) + 64'(pnv_pkg::MS_PER_SEC) - 64'd1)
        / 64'(pnv_pkg::MS_PER_SEC);

    pnv_pkg::state_t state_reg, state_next;

    logic [16:0]       phase_reg [3];
    logic [16:0]       inc_reg   [3];
    logic [1:0]        duty_reg  [3];
    logic [3:0]        level_reg [3];
    logic signed [4:0] step_reg  [3];
    logic [7:0]        len_reg   [3];
    logic [17:0]       cd_reg    [3];
    logic [21:0]       left_reg  [3];
    logic [14:0]       noise_reg;

    pnv_pkg::item_t    cur_reg;
    logic [1:0]        vidx_reg;
    logic signed [6:0] mix_reg;
    logic              live_reg;
    logic signed [17:0] prod_reg;
    logic [21:0]       samples_reg;
    logic [16:0]       ninc_reg;
    logic [16:0]       out_data_reg;
    logic              out_valid_reg;

    pnv_pkg::div_req_t div_req;
    logic              div_busy, div_done;
    logic [31:0]       div_q;
    logic [21:0]       samples_calc;

    pnv_div #(.DW(32), .VW(16)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_req.start),
        .dividend (div_req.dividend),
        .divisor  (div_req.divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    assign samples_calc = 22'((64'(q_item.duration_ms) * SAMPLES_MUL) >> SAMPLES_SHIFT);

    // Per-voice tick datapath for voice vidx_reg
    logic [16:0]       v_ph, v_ph_new, v_inc, v_sum;
    logic [14:0]       v_lfsr_new;
    logic [15:0]       v_pulse;
    logic              v_live, v_pos, v_zero;
    logic signed [6:0] v_contrib;
    logic [17:0]       v_reload, v_cd_new, v_cd_dec;
    logic [3:0]        v_lvl_new;
    logic signed [5:0] v_nv;
    logic [10:0]       scale;
    logic [3:0]        mv;
    logic signed [17:0] prod_full;
    logic signed [15:0] sat;
    logic              out_free;

    always_comb begin
        v_ph       = phase_reg[vidx_reg];
        v_inc      = inc_reg[vidx_reg];
        v_live     = (left_reg[vidx_reg] != 22'd0);
        v_sum      = v_ph + v_inc;
        v_pulse    = v_ph[15:0] + v_inc[15:0];
        v_lfsr_new = noise_reg;
        v_ph_new   = v_ph;
        v_pos      = 1'b0;
        v_zero     = 1'b0;
        if (vidx_reg == pnv_pkg::NOISE_VOICE) begin
            v_ph_new = {1'b0, v_sum[15:0]};
            if (v_sum[16]) begin
                v_lfsr_new = {noise_reg[0] ^ noise_reg[1], noise_reg[14:1]};
            end
            v_pos = v_lfsr_new[0];
        end else if (v_inc != 17'd0) begin
            v_ph_new = {1'b0, v_pulse};
            v_pos    = (v_pulse < pnv_pkg::duty_threshold(duty_reg[vidx_reg]));
        end else begin
            v_zero = 1'b1;
        end
        if (v_zero) begin
            v_contrib = 7'sd0;
        end else if (v_pos) begin
            v_contrib = $signed({3'b000, level_reg[vidx_reg]});
        end else begin
            v_contrib = -$signed({3'b000, level_reg[vidx_reg]});
        end

        v_reload  = 18'({10'd0, len_reg[vidx_reg]} * 18'(ENV_TICKS));
        v_cd_dec  = cd_reg[vidx_reg] - 18'd1;
        v_cd_new  = cd_reg[vidx_reg];
        v_lvl_new = level_reg[vidx_reg];
        v_nv      = $signed({2'b00, level_reg[vidx_reg]})
                  + $signed({step_reg[vidx_reg][4], step_reg[vidx_reg]});
        if (len_reg[vidx_reg] != 8'd0 && step_reg[vidx_reg] != 5'sd0
                && cd_reg[vidx_reg] != 18'd0) begin
            v_cd_new = v_cd_dec;
            if (v_cd_dec == 18'd0) begin
                v_cd_new = v_reload;
                if (v_nv < 6'sd0) begin
                    v_lvl_new = 4'd0;
                end else if (v_nv > 6'sd15) begin
                    v_lvl_new = pnv_pkg::LEVEL_MAX;
                end else begin
                    v_lvl_new = v_nv[3:0];
                end
            end
        end

        mv        = (master > pnv_pkg::MASTER_MAX) ? pnv_pkg::MASTER_MAX : master;
        scale     = 11'(mv) * pnv_pkg::SCALE_STEP;
        prod_full = mix_reg * $signed({1'b0, scale});
        if (prod_reg > 18'sd32767) begin
            sat = 16'sh7FFF;
        end else if (prod_reg < -18'sd32768) begin
            sat = -16'sh8000;
        end else begin
            sat = prod_reg[15:0];
        end
        out_free = !out_valid_reg || m_tready;
    end

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pnv_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next       = state_reg;
        q_pop            = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = pnv_pkg::PHASE_ONE;
        div_req.divisor  = (q_item.noise_period == 16'd0) ?
                           pnv_pkg::NOISE_DEF : q_item.noise_period;
        case (state_reg)
            pnv_pkg::ST_IDLE: begin
                if (q_valid) begin
                    q_pop = 1'b1;
                    case (q_item.op)
                        pnv_pkg::OP_TICK:  state_next = pnv_pkg::ST_VOICE;
                        pnv_pkg::OP_PULSE: state_next = pnv_pkg::ST_LOAD;
                        pnv_pkg::OP_NOISE: begin
                            div_req.start = 1'b1;
                            state_next    = pnv_pkg::ST_DIVN;
                        end
                        default: state_next = pnv_pkg::ST_IDLE;
                    endcase
                end
            end
            pnv_pkg::ST_VOICE: begin
                if (vidx_reg == pnv_pkg::NOISE_VOICE) begin
                    state_next = pnv_pkg::ST_MUL;
                end
            end
            pnv_pkg::ST_MUL: state_next = pnv_pkg::ST_OUT;
            pnv_pkg::ST_OUT: begin
                if (out_free) begin
                    state_next = pnv_pkg::ST_IDLE;
                end
            end
            pnv_pkg::ST_DIVN: begin
                if (div_done) begin
                    state_next = pnv_pkg::ST_LOAD;
                end
            end
            pnv_pkg::ST_LOAD: state_next = pnv_pkg::ST_IDLE;
            default: state_next = pnv_pkg::ST_IDLE;
        endcase
    end

    // Datapath and voice state
    logic [1:0] ld_k;
    assign ld_k = (cur_reg.op == pnv_pkg::OP_NOISE) ? pnv_pkg::NOISE_VOICE : cur_reg.voice;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < pnv_pkg::VOICES; k++) begin
                phase_reg[k] <= '0;
                inc_reg[k]   <= '0;
                duty_reg[k]  <= '0;
                level_reg[k] <= '0;
                step_reg[k]  <= '0;
                len_reg[k]   <= '0;
                cd_reg[k]    <= '0;
                left_reg[k]  <= '0;
            end
            noise_reg     <= pnv_pkg::LFSR_SEED;
            vidx_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= (state_reg == pnv_pkg::ST_OUT && out_free)
                          || (out_valid_reg && !m_tready);
            case (state_reg)
                pnv_pkg::ST_IDLE: begin
                    vidx_reg    <= '0;
                    mix_reg     <= '0;
                    live_reg    <= 1'b0;
                    cur_reg     <= q_item;
                    samples_reg <= samples_calc;
                    if (q_valid && q_item.op == pnv_pkg::OP_SIL) begin
                        left_reg[q_item.voice]  <= '0;
                        level_reg[q_item.voice] <= '0;
                    end
                    if (q_valid && q_item.op == pnv_pkg::OP_SILALL) begin
                        for (int k = 0; k < pnv_pkg::VOICES; k++) begin
                            left_reg[k]  <= '0;
                            level_reg[k] <= '0;
                        end
                    end
                end
                pnv_pkg::ST_VOICE: begin
                    vidx_reg <= (vidx_reg == pnv_pkg::NOISE_VOICE) ? 2'd0 : vidx_reg + 2'd1;
                    if (v_live) begin
                        phase_reg[vidx_reg] <= v_ph_new;
                        level_reg[vidx_reg] <= v_lvl_new;
                        cd_reg[vidx_reg]    <= v_cd_new;
                        left_reg[vidx_reg]  <= left_reg[vidx_reg] - 22'd1;
                        mix_reg             <= mix_reg + v_contrib;
                        live_reg            <= live_reg || (left_reg[vidx_reg] != 22'd1);
                        if (vidx_reg == pnv_pkg::NOISE_VOICE) begin
                            noise_reg <= v_lfsr_new;
                        end
                    end
                end
                pnv_pkg::ST_MUL: prod_reg <= prod_full;
                pnv_pkg::ST_OUT: begin
                    if (out_free) begin
                        out_data_reg <= {live_reg, sat};
                    end
                end
                pnv_pkg::ST_DIVN: begin
                    if (div_done) ninc_reg <= div_q[16:0];
                end
                pnv_pkg::ST_LOAD: begin
                    if (cur_reg.op == pnv_pkg::OP_NOISE) begin
                        inc_reg[ld_k] <= ninc_reg;
                        noise_reg     <= pnv_pkg::LFSR_SEED;
                    end else begin
                        inc_reg[ld_k]  <= {1'b0, cur_reg.phase_step};
                        duty_reg[ld_k] <= cur_reg.duty;
                    end
                    level_reg[ld_k] <= (cur_reg.volume > 8'd15) ?
                                       pnv_pkg::LEVEL_MAX : cur_reg.volume[3:0];
                    step_reg[ld_k]  <= cur_reg.env_direction;
                    len_reg[ld_k]   <= cur_reg.env_period;
                    cd_reg[ld_k]    <= 18'({10'd0, cur_reg.env_period} * 18'(ENV_TICKS));
                    left_reg[ld_k]  <= samples_reg;
                    phase_reg[ld_k] <= '0;
                end
                default: vidx_reg <= '0;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_data_reg};

    assert property (@(posedge aclk) disable iff (!aresetn)
        div_busy |-> (state_reg == pnv_pkg::ST_DIVN))
        else $error("divider running outside a noise load");
    assert property (@(posedge aclk) disable iff (!aresetn)
        vidx_reg != pnv_pkg::NO_VOICE)
        else $error("voice index out of range");
    assert property (@(posedge aclk) disable iff (!aresetn)
        noise_reg != 15'd0)
        else $error("noise LFSR locked at zero");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pnv_pkg::ST_OUT && out_free) |=> out_valid_reg)
        else $error("tick result lost");
endmodule

/* hw/rtl/pulse_noise_voice_synth_unit.sv */
// Top level of the pulse/noise voice synthesizer: master volume register,
// front end queue and back end sequencer. Depends on pnv_pkg, pnv_front, pnv_back.
//
// Usage:
//   s_ channel carries commands (tick, load pulse, load noise, silence voice,
//   silence all). Only a tick produces a transaction on the m_ channel: the
//   mixed 16-bit sample and the any-active flag. Invalid commands are dropped.
//   cfg_ channel writes the master volume (4 bits); it is always ready.
//   Commands pass through a two-entry queue; s_tready drops only when it fills.
//   With the back end idle, a tick passes the queue, the dequeue in the idle
//   state, one voice state per voice, the multiply state and the saturate into
//   the output register before its result is on m_; it holds the back end that long.
//   A pulse load passes through the load state; a noise load first waits in the
//   divide state for the divider, which forms the noise step two quotient bits per
//   cycle. Silence commands are applied in the idle state as they are dequeued.
//   Reset (aresetn low, synchronous) silences all voices, seeds the LFSR and
//   sets master volume to 10.
//   If m_tready stays low the result is held, the sequencer waits with the
//   next tick's result and the queue accepts commands until it fills.
module pulse_noise_voice_synth_unit #(
    parameter int SAMPLE_RATE = pnv_pkg::SAMPLE_RATE_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // phase_step, duty, volume, env_direction, env_period, duration_ms,
    // noise_period, zero pad
    input  logic [71:0] s_tdata,
    // command, voice
    input  logic [4:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // sample, any_active, zero pad
    output logic [23:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data
);
    logic [3:0]     master_reg;
    logic           q_valid, q_pop;
    pnv_pkg::item_t q_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            master_reg <= pnv_pkg::MASTER_RESET;
        end else if (cfg_valid && cfg_ready) begin
            master_reg <= cfg_data;
        end
    end

    pnv_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    pnv_back #(.SAMPLE_RATE(SAMPLE_RATE)) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .master   (master_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );
endmodule
